/* sv/fcc_pkg.sv */
package fcc_pkg;

   localparam int SEQ_WIDTH_DEF = 12;
   localparam int TIME_W        = 64;
   localparam int COUNT_W       = 8;
   localparam int ERR_W         = 32;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int TPF_W         = 16;
   localparam int LIMIT_W       = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_TICKS_PER_FRAME  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SEQ_CHECK_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BROKEN_LIMIT     = 2'd2;

   localparam logic [TPF_W-1:0]   TICKS_PER_FRAME_RST = 16'd2048;
   localparam logic               SEQ_CHECK_RST       = 1'b1;
   localparam logic [LIMIT_W-1:0] BROKEN_LIMIT_RST    = 16'd1000;

endpackage

/* sv/frame_continuity_checker.sv */
// An accepted req beat becomes its rsp beat through the input register and then the result register.
// Throughput: one beat per cycle while rsp_tready is held high; the check of one header is a 16x8
//    multiply, a 64-bit add and compare, and a sequence-id add, combinational between the two registers.
// Reset: synchronous, active high; clears both stages, the continuity state and the counters,
//    and loads the register defaults.
module frame_continuity_checker #(
   parameter int SEQ_WIDTH = fcc_pkg::SEQ_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   // seq_id, frame_time, frame_count; zero padded to whole bytes
   input  logic [((SEQ_WIDTH + fcc_pkg::TIME_W + fcc_pkg::COUNT_W + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // seq_delta, seq_new_interval, seq_expected, ts_mismatch, ts_new_interval, ts_expected,
   // seq_error_total, ts_error_total, seq_broken, ts_broken, seq_min_jump, seq_max_jump
   output logic [((4 * SEQ_WIDTH + 2 * fcc_pkg::TIME_W + 6 + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic csr_wr_en,
   input  logic [fcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fcc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fcc_pkg::*;

   localparam int REQ_W    = ((SEQ_WIDTH + TIME_W + COUNT_W + 7) / 8) * 8;
   localparam int RSP_BITS = 4 * SEQ_WIDTH + 2 * TIME_W + 6;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;
   localparam logic [SEQ_WIDTH-1:0] SEQ_HALF = {1'b1, {(SEQ_WIDTH - 1){1'b0}}};

   logic [TPF_W-1:0]   tpf_ff;
   logic               seq_en_ff;
   logic [LIMIT_W-1:0] limit_ff;

   logic             req_valid_ff;
   logic [REQ_W-1:0] req_data_ff;
   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;
   logic [RSP_W-1:0] rsp_data_in;
   logic             advance;

   logic [SEQ_WIDTH-1:0] last_seq_ff, last_seq_in;
   logic [TIME_W-1:0]    last_time_ff;
   logic                 seq_first_ff, seq_first_in;
   logic                 seq_in_err_ff, seq_in_err_in;
   logic [ERR_W-1:0]     seq_errors_ff, seq_errors_in;
   logic                 seq_flagged_ff, seq_flagged_in;
   logic signed [SEQ_WIDTH-1:0] low_jump_ff, low_jump_in;
   logic [SEQ_WIDTH-1:0] high_jump_ff, high_jump_in;
   logic                 ts_first_ff, ts_first_in;
   logic                 ts_in_err_ff, ts_in_err_in;
   logic [ERR_W-1:0]     ts_errors_ff, ts_errors_in;
   logic                 ts_flagged_ff, ts_flagged_in;

   logic [SEQ_WIDTH-1:0] id;
   logic [TIME_W-1:0]    now;
   logic [COUNT_W-1:0]   count;
   logic [SEQ_WIDTH-1:0] expected;
   logic [SEQ_WIDTH-1:0] diff_mod;
   logic signed [SEQ_WIDTH:0] delta;
   logic                 seq_event;
   logic [TPF_W+COUNT_W-1:0] step_full;
   logic [TIME_W-1:0]    ts_exp;
   logic                 ts_bad;
   logic                 ts_event;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign id    = req_data_ff[SEQ_WIDTH-1:0];
   assign now   = req_data_ff[SEQ_WIDTH+TIME_W-1:SEQ_WIDTH];
   assign count = req_data_ff[SEQ_WIDTH+TIME_W+COUNT_W-1:SEQ_WIDTH+TIME_W];

   always_comb begin
      last_seq_in    = last_seq_ff;
      seq_first_in   = seq_first_ff;
      seq_in_err_in  = seq_in_err_ff;
      seq_errors_in  = seq_errors_ff;
      seq_flagged_in = seq_flagged_ff;
      low_jump_in    = low_jump_ff;
      high_jump_in   = high_jump_ff;
      expected       = '0;
      diff_mod       = '0;
      delta          = '0;
      seq_event      = 1'b0;

      if (seq_en_ff) begin
         expected = last_seq_ff + SEQ_WIDTH'(count);
         diff_mod = id - expected;
         delta    = (diff_mod > SEQ_HALF) ? $signed({1'b1, diff_mod}) : $signed({1'b0, diff_mod});
         if (delta == '0) begin
            seq_in_err_in = 1'b0;
         end else begin
            seq_errors_in = (seq_errors_ff == '1) ? seq_errors_ff : seq_errors_ff + 1'b1;
            if (delta > $signed({1'b0, high_jump_ff})) begin
               high_jump_in = delta[SEQ_WIDTH-1:0];
            end
            if (delta < $signed({low_jump_ff[SEQ_WIDTH-1], low_jump_ff})) begin
               low_jump_in = delta[SEQ_WIDTH-1:0];
            end
            priority if (seq_first_ff) begin
               seq_first_in = 1'b0;
            end else if (!seq_in_err_ff) begin
               seq_event     = 1'b1;
               seq_in_err_in = 1'b1;
            end else begin
               seq_in_err_in = 1'b1;
            end
         end
         if (seq_errors_in > ERR_W'(limit_ff)) begin
            seq_flagged_in = 1'b1;
         end
         last_seq_in = id;
      end

      step_full     = tpf_ff * count;
      ts_exp        = last_time_ff + TIME_W'(step_full[TPF_W-1:0]);
      ts_bad        = 1'b0;
      ts_event      = 1'b0;
      ts_first_in   = ts_first_ff;
      ts_in_err_in  = ts_in_err_ff;
      ts_errors_in  = ts_errors_ff;
      ts_flagged_in = ts_flagged_ff;
      if (last_time_ff != '0 && now != ts_exp) begin
         ts_bad       = 1'b1;
         ts_errors_in = (ts_errors_ff == '1) ? ts_errors_ff : ts_errors_ff + 1'b1;
         priority if (ts_first_ff) begin
            ts_first_in = 1'b0;
         end else if (!ts_in_err_ff) begin
            ts_event     = 1'b1;
            ts_in_err_in = 1'b1;
         end else begin
            ts_in_err_in = 1'b1;
         end
      end else begin
         ts_in_err_in = 1'b0;
      end
      if (ts_errors_in > ERR_W'(limit_ff)) begin
         ts_flagged_in = 1'b1;
      end

      rsp_data_in = '0;
      rsp_data_in[RSP_BITS-1:0] = {high_jump_in, low_jump_in, ts_flagged_in, seq_flagged_in,
                                   ts_errors_in, seq_errors_in, ts_exp, ts_event, ts_bad,
                                   expected, seq_event, delta};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpf_ff         <= TICKS_PER_FRAME_RST;
         seq_en_ff      <= SEQ_CHECK_RST;
         limit_ff       <= BROKEN_LIMIT_RST;
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         last_seq_ff    <= '0;
         last_time_ff   <= '0;
         seq_first_ff   <= 1'b1;
         seq_in_err_ff  <= 1'b0;
         seq_errors_ff  <= '0;
         seq_flagged_ff <= 1'b0;
         low_jump_ff    <= '0;
         high_jump_ff   <= '0;
         ts_first_ff    <= 1'b1;
         ts_in_err_ff   <= 1'b0;
         ts_errors_ff   <= '0;
         ts_flagged_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_TICKS_PER_FRAME:  tpf_ff    <= csr_wdata[TPF_W-1:0];
               REG_SEQ_CHECK_ENABLE: seq_en_ff <= csr_wdata[0];
               REG_BROKEN_LIMIT:     limit_ff  <= csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            last_seq_ff    <= last_seq_in;
            last_time_ff   <= now;
            seq_first_ff   <= seq_first_in;
            seq_in_err_ff  <= seq_in_err_in;
            seq_errors_ff  <= seq_errors_in;
            seq_flagged_ff <= seq_flagged_in;
            low_jump_ff    <= low_jump_in;
            high_jump_ff   <= high_jump_in;
            ts_first_ff    <= ts_first_in;
            ts_in_err_ff   <= ts_in_err_in;
            ts_errors_ff   <= ts_errors_in;
            ts_flagged_ff  <= ts_flagged_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_data_ff <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_seq_event_has_jump: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[SEQ_WIDTH+1]) |-> (rsp_tdata[SEQ_WIDTH:0] != '0))
      else $error("sequence interval event without a jump");

   a_ts_event_has_mismatch: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2*SEQ_WIDTH+3]) |-> rsp_tdata[2*SEQ_WIDTH+2])
      else $error("timestamp interval event without a mismatch");

   a_seq_broken_latched: assert property (@(posedge clock) disable iff (reset)
      seq_flagged_ff |=> seq_flagged_ff)
      else $error("sequence broken flag dropped");

   a_ts_broken_latched: assert property (@(posedge clock) disable iff (reset)
      ts_flagged_ff |=> ts_flagged_ff)
      else $error("timestamp broken flag dropped");

   a_first_run_excl: assert property (@(posedge clock) disable iff (reset)
      seq_first_ff |-> !seq_in_err_ff)
      else $error("sequence error run entered before the first mismatch");

endmodule

/* dv/tb_frame_continuity_checker.sv */
`timescale 1ns / 100ps

module tb_frame_continuity_checker;
   import fcc_pkg::*;

   localparam int SW        = SEQ_WIDTH_DEF;
   localparam int REQ_W     = ((SW + TIME_W + COUNT_W + 7) / 8) * 8;
   localparam int RSP_BITS  = 4 * SW + 2 * TIME_W + 6;
   localparam int RSP_W     = ((RSP_BITS + 7) / 8) * 8;
   localparam int SEQ_SPAN  = 1 << SW;
   localparam int SEQ_HALF  = 1 << (SW - 1);
   localparam int LATENCY   = 2;
   localparam int HOLD_AT   = 200;
   localparam int HOLD_LEN  = 300;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic [RSP_W-RSP_BITS-1:0] pad;
      logic [SW-1:0]             max_jump;
      logic [SW-1:0]             min_jump;
      logic                      ts_broken;
      logic                      seq_broken;
      logic [ERR_W-1:0]          ts_total;
      logic [ERR_W-1:0]          seq_total;
      logic [TIME_W-1:0]         ts_expected;
      logic                      ts_new;
      logic                      ts_mismatch;
      logic [SW-1:0]             seq_expected;
      logic                      seq_new;
      logic [SW:0]               seq_delta;
   } rsp_beat_type;

   class continuity_scoreboard;
      logic [TPF_W-1:0]   tpf;
      logic               seq_en;
      logic [LIMIT_W-1:0] limit;

      logic [SW-1:0]     prev_seq;
      logic [TIME_W-1:0] prev_time;
      bit                seq_first, seq_run, seq_flag;
      bit                ts_first, ts_run, ts_flag;
      logic [ERR_W-1:0]  seq_errs, ts_errs;
      int                low_jump, high_jump;

      rsp_beat_type expected_beats[$];
      int           fail_count;

      function new();
         tpf       = TICKS_PER_FRAME_RST;
         seq_en    = SEQ_CHECK_RST;
         limit     = BROKEN_LIMIT_RST;
         prev_seq  = '0;
         prev_time = '0;
         seq_first = 1'b1;
         seq_run   = 1'b0;
         seq_flag  = 1'b0;
         ts_first  = 1'b1;
         ts_run    = 1'b0;
         ts_flag   = 1'b0;
         seq_errs  = '0;
         ts_errs   = '0;
         low_jump  = 0;
         high_jump = 0;
         fail_count = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_TICKS_PER_FRAME:  tpf = val[TPF_W-1:0];
            REG_SEQ_CHECK_ENABLE: seq_en = val[0];
            REG_BROKEN_LIMIT:     limit = val[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_header(logic [SW-1:0] id, logic [TIME_W-1:0] stamp,
                                logic [COUNT_W-1:0] cnt);
         rsp_beat_type e;
         int           delta;
         logic [23:0]  prod;
         logic [15:0]  step;
         e = '0;
         if (seq_en) begin
            e.seq_expected = prev_seq + cnt;
            delta = int'(id) - int'(e.seq_expected);
            if (delta > SEQ_HALF) delta -= SEQ_SPAN;
            else if (delta < -(SEQ_HALF - 1)) delta += SEQ_SPAN;
            if (delta == 0) begin
               seq_run = 1'b0;
            end else begin
               if (seq_errs != '1) seq_errs++;
               if (delta > high_jump) high_jump = delta;
               if (delta < low_jump) low_jump = delta;
               if (seq_first) begin
                  seq_first = 1'b0;
               end else if (!seq_run) begin
                  e.seq_new = 1'b1;
                  seq_run = 1'b1;
               end
            end
            if (seq_errs > limit) seq_flag = 1'b1;
            prev_seq = id;
            e.seq_delta = (SW + 1)'(delta);
         end

         prod = tpf * cnt;
         step = prod[15:0];
         e.ts_expected = prev_time + TIME_W'(step);
         if (prev_time != '0 && (stamp - prev_time) != TIME_W'(step)) begin
            e.ts_mismatch = 1'b1;
            if (ts_errs != '1) ts_errs++;
            if (ts_first) begin
               ts_first = 1'b0;
            end else if (!ts_run) begin
               e.ts_new = 1'b1;
               ts_run = 1'b1;
            end
         end else begin
            ts_run = 1'b0;
         end
         if (ts_errs > limit) ts_flag = 1'b1;
         prev_time = stamp;

         e.seq_total  = seq_errs;
         e.ts_total   = ts_errs;
         e.seq_broken = seq_flag;
         e.ts_broken  = ts_flag;
         e.min_jump   = SW'(low_jump);
         e.max_jump   = SW'(high_jump);
         expected_beats = {expected_beats, e};
      endfunction

      function void cmp(string field, logic [63:0] e, logic [63:0] a);
         if (a !== e) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, e, a);
         end
      endfunction

      function void check_beat(logic [RSP_W-1:0] d);
         rsp_beat_type a, e;
         a = d;
         if (expected_beats.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected rsp beat: expected none, actual %h", $time, d);
            return;
         end
         e = expected_beats.pop_front();
         cmp("seq_delta", 64'(e.seq_delta), 64'(a.seq_delta));
         cmp("seq_new_interval", 64'(e.seq_new), 64'(a.seq_new));
         cmp("seq_expected", 64'(e.seq_expected), 64'(a.seq_expected));
         cmp("ts_mismatch", 64'(e.ts_mismatch), 64'(a.ts_mismatch));
         cmp("ts_new_interval", 64'(e.ts_new), 64'(a.ts_new));
         cmp("ts_expected", e.ts_expected, a.ts_expected);
         cmp("seq_error_total", 64'(e.seq_total), 64'(a.seq_total));
         cmp("ts_error_total", 64'(e.ts_total), 64'(a.ts_total));
         cmp("seq_broken", 64'(e.seq_broken), 64'(a.seq_broken));
         cmp("ts_broken", 64'(e.ts_broken), 64'(a.ts_broken));
         cmp("seq_min_jump", 64'(e.min_jump), 64'(a.min_jump));
         cmp("seq_max_jump", 64'(e.max_jump), 64'(a.max_jump));
      endfunction
   endclass

   logic                   clock;
   logic                   reset      = 1'b1;
   logic [REQ_W-1:0]       req_tdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_wr_en  = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   continuity_scoreboard sb;
   int tx_idle_max = 6;
   int rx_idle_max = 6;
   int rx_beats    = 0;

   frame_continuity_checker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #200000;
      $display("FAIL frame_continuity_checker");
      $finish;
   end

   task automatic send_hdr(logic [SW-1:0] id, logic [TIME_W-1:0] stamp,
                           logic [COUNT_W-1:0] cnt);
      int gap;
      gap = (tx_idle_max == 0) ? 0 : $urandom_range(0, tx_idle_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= REQ_W'({cnt, stamp, id});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_header(id, stamp, cnt);
   endtask

   task automatic send_rel(int seq_off, logic [TIME_W-1:0] time_off, logic [COUNT_W-1:0] cnt);
      logic [SW-1:0]     id;
      logic [23:0]       prod;
      logic [TIME_W-1:0] stamp;
      prod  = sb.tpf * cnt;
      id    = SW'(sb.prev_seq + cnt + seq_off);
      stamp = sb.prev_time + TIME_W'(prod[15:0]) + time_off;
      send_hdr(id, stamp, cnt);
   endtask

   task automatic send_random();
      int                 r;
      logic [COUNT_W-1:0] cnt;
      int                 seq_off;
      logic [TIME_W-1:0]  time_off;
      r = $urandom_range(0, 99);
      if (r < 5) cnt = '0;
      else if (r < 10) cnt = 8'hFF;
      else if (r < 25) cnt = COUNT_W'($urandom_range(1, 255));
      else cnt = COUNT_W'($urandom_range(1, 8));
      r = $urandom_range(0, 99);
      if (r < 6) seq_off = $urandom_range(1, 3);
      else if (r < 10) seq_off = -$urandom_range(1, 3);
      else if (r < 14) seq_off = $urandom_range(0, SEQ_SPAN - 1);
      else seq_off = 0;
      r = $urandom_range(0, 99);
      time_off = '0;
      if (r < 7) time_off = TIME_W'($urandom_range(1, 255));
      else if (r < 10) time_off = {$urandom, $urandom};
      if (r >= 95) send_hdr(SW'(sb.prev_seq + cnt + seq_off), '0, cnt);
      else send_rel(seq_off, time_off, cnt);
   endtask

   task automatic wait_idle();
      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic set_regs(logic [15:0] tpf, logic [15:0] en, logic [15:0] lim);
      csr_wr_en <= 1'b1;
      csr_index <= REG_TICKS_PER_FRAME;
      csr_wdata <= tpf;
      @(posedge clock);
      sb.write_reg(REG_TICKS_PER_FRAME, tpf);
      csr_index <= REG_SEQ_CHECK_ENABLE;
      csr_wdata <= en;
      @(posedge clock);
      sb.write_reg(REG_SEQ_CHECK_ENABLE, en);
      csr_index <= REG_BROKEN_LIMIT;
      csr_wdata <= lim;
      @(posedge clock);
      sb.write_reg(REG_BROKEN_LIMIT, lim);
      csr_index <= REG_SPARE;
      csr_wdata <= CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(logic [15:0] tpf, logic [15:0] en, logic [15:0] lim,
                            int n, int tx_max, int rx_max);
      set_regs(tpf, en, lim);
      tx_idle_max = tx_max;
      rx_idle_max = rx_max;
      repeat (n) send_random();
      req_tvalid <= 1'b0;
      wait_idle();
   endtask

   // receiver: random back-pressure, one long hold-off to fill the pipeline
   initial begin
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = (rx_idle_max == 0) ? 0 : $urandom_range(0, rx_idle_max);
         if (rx_beats == HOLD_AT) gap = HOLD_LEN;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_beat(rsp_tdata);
         rx_beats++;
      end
   end

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first mismatch absorbed, timestamp check skipped while previous is zero
      send_hdr(12'hFFF, 64'h0, 8'd1);
      send_hdr(12'h000, 64'hFFFF_FFFF_FFFF_F000, 8'd1);
      send_rel(0, 64'd0, 8'd1);
      // timestamp wraps to zero
      send_rel(0, 64'd0, 8'd1);
      send_rel(0, 64'd0, 8'd2);
      send_rel(0, 64'd0, 8'd1);
      // error runs on both checks
      send_rel(5, 64'd0, 8'd1);
      send_rel(7, 64'd3, 8'd1);
      send_rel(0, 64'd3, 8'd1);
      send_rel(0, 64'd0, 8'd1);
      // jump extremes and folding
      send_rel(SEQ_HALF, 64'd0, 8'd1);
      send_rel(0, 64'd0, 8'd1);
      send_rel(-(SEQ_HALF - 1), 64'd0, 8'd1);
      send_rel(0, 64'd0, 8'd0);
      send_rel(SEQ_HALF + 1, 64'd0, 8'd255);
      send_rel(-SEQ_HALF, 64'd0, 8'd255);
      send_rel(0, 64'd0, 8'd255);
      send_hdr(12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
      send_hdr(12'h000, 64'h0, 8'h00);
      send_rel(0, 64'h8000_0000_0000_0000, 8'd1);
      send_rel(0, 64'd0, 8'd1);
      send_rel(0, 64'h8000_0000_0000_0000, 8'd1);
      req_tvalid <= 1'b0;
      wait_idle();

      run_phase(TICKS_PER_FRAME_RST, 16'd1, BROKEN_LIMIT_RST, 150, 6, 6);
      run_phase(16'hFFFF, 16'd1, 16'd0, 130, 0, 0);
      run_phase(16'h0000, 16'hFFFE, 16'hFFFF, 120, 6, 0);
      run_phase(16'($urandom), 16'd1, 16'd20, 150, 0, 6);
      run_phase(16'd1, 16'd1, 16'd5, 150, 6, 6);

      repeat (10) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("PASS frame_continuity_checker");
      end else begin
         $display("FAIL frame_continuity_checker");
      end
      $finish;
   end

endmodule

/* frame_continuity_checker.f */
sv/fcc_pkg.sv
sv/frame_continuity_checker.sv
dv/tb_frame_continuity_checker.sv
